@@ rtl/mma_pkg.sv @@
// ----------------------------------------------------------------------------
// mma_pkg
// Shared constants, command codes and control/status types for the
// matrix multiply/add/transpose unit.
// ----------------------------------------------------------------------------
package mma_pkg;

   localparam int MAX_DIM    = 8;
   localparam int DATA_WIDTH = 32;
   localparam int CAPACITY   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W      = $clog2(CAPACITY + 2);
   localparam int DIM_W      = $clog2(MAX_DIM + 1);
   localparam int PROD_W     = (2 * DIM_W > CNT_W) ? 2 * DIM_W : CNT_W;

   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DIM_W;

   localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RUN    = 2'd2;

   localparam logic [1:0] OP_MUL = 2'd0;
   localparam logic [1:0] OP_ADD = 2'd1;
   localparam logic [1:0] OP_TRN = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_OP_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_ROWS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_COLS   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_COLS_B = 2'd3;

   typedef struct packed {
      logic start;
      logic issue;
      logic next_elem;
      logic load_a;
      logic load_b;
      logic clear_counts;
      logic zero_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic run_ok;
      logic k_last;
      logic elem_last;
      logic acc_done;
   } dp_status_type;

endpackage

@@ rtl/mma_ctrl.sv @@
// ----------------------------------------------------------------------------
// mma_ctrl
// Sequencer: accepts loads and run commands, steps the datapath through the
// element loop and hands each finished element to the result channel.
// ----------------------------------------------------------------------------
module mma_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [mma_pkg::CMD_W-1:0]        req_cmd,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_last,
   output logic                             rsp_error,
   output mma_pkg::ctrl_cmd_type            dp_cmd,
   input  mma_pkg::dp_status_type           dp_status
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ISSUE = 3'd1;
   localparam logic [2:0] ST_WAIT  = 3'd2;
   localparam logic [2:0] ST_OUT   = 3'd3;
   localparam logic [2:0] ST_ERR   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT) || (state_ff == ST_ERR);
   assign rsp_error = (state_ff == ST_ERR);
   assign rsp_last  = (state_ff == ST_ERR) || dp_status.elem_last;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid && !rsp_stall;

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      dp_cmd.zero_out = (state_ff == ST_ERR);
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_cmd)
                  mma_pkg::CMD_LOAD_A: dp_cmd.load_a = 1'b1;
                  mma_pkg::CMD_LOAD_B: dp_cmd.load_b = 1'b1;
                  mma_pkg::CMD_RUN: begin
                     dp_cmd.clear_counts = 1'b1;
                     dp_cmd.start        = 1'b1;
                     state_in = dp_status.run_ok ? ST_ISSUE : ST_ERR;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_ISSUE: begin
            dp_cmd.issue = 1'b1;
            if (dp_status.k_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (dp_status.acc_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_xfer) begin
               if (dp_status.elem_last) begin
                  state_in = ST_IDLE;
               end else begin
                  dp_cmd.next_elem = 1'b1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ERR: begin
            if (rsp_xfer) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/mma_dp.sv @@
// ----------------------------------------------------------------------------
// mma_dp
// Datapath: configuration registers, both element stores, load counts,
// loop counters, address generation and the read/multiply/accumulate pipe.
// ----------------------------------------------------------------------------
module mma_dp (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_write,
   input  logic [mma_pkg::CSR_IDX_W-1:0]             csr_index,
   input  logic [mma_pkg::CSR_DATA_W-1:0]            csr_data,
   input  logic signed [mma_pkg::DATA_WIDTH-1:0]     req_value,
   output logic signed [mma_pkg::DATA_WIDTH-1:0]     rsp_result_value,
   input  mma_pkg::ctrl_cmd_type                     dp_cmd,
   output mma_pkg::dp_status_type                    dp_status
);

   localparam int DW = mma_pkg::DATA_WIDTH;
   localparam int AW = mma_pkg::ADDR_W;
   localparam int CW = mma_pkg::CNT_W;
   localparam int NW = mma_pkg::DIM_W;
   localparam int PW = mma_pkg::PROD_W;

   logic [1:0]    op_mode_ff;
   logic [NW-1:0] num_rows_ff;
   logic [NW-1:0] num_cols_ff;
   logic [NW-1:0] num_cols_b_ff;

   logic [DW-1:0] first_store_ff  [mma_pkg::CAPACITY];
   logic [DW-1:0] second_store_ff [mma_pkg::CAPACITY];
   logic [CW-1:0] first_cnt_ff,  first_cnt_in;
   logic [CW-1:0] second_cnt_ff, second_cnt_in;

   logic [NW-1:0] idx1_ff, idx1_in;
   logic [NW-1:0] idx2_ff, idx2_in;
   logic [NW-1:0] idx3_ff, idx3_in;
   logic [NW-1:0] lim1, lim2, lim3;
   logic [PW-1:0] a_lin, b_lin;

   logic [DW-1:0] a_rd_ff, b_rd_ff;
   logic          p1_valid_ff, p1_first_ff, p1_last_ff;
   logic [DW-1:0] prod_ff, sum_ff, a2_ff;
   logic          p2_valid_ff, p2_first_ff, p2_last_ff;
   logic [DW-1:0] acc_ff, acc_in, pick;
   logic          done_ff;

   logic          dims_ok;
   logic [PW-1:0] rc, ccb;
   logic          first_ok, second_ok;

   // Configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff    <= mma_pkg::OP_MUL;
         num_rows_ff   <= NW'(mma_pkg::MAX_DIM);
         num_cols_ff   <= NW'(mma_pkg::MAX_DIM);
         num_cols_b_ff <= NW'(mma_pkg::MAX_DIM);
      end else if (csr_write) begin
         case (csr_index)
            mma_pkg::REG_OP_MODE:    op_mode_ff    <= csr_data[1:0];
            mma_pkg::REG_NUM_ROWS:   num_rows_ff   <= csr_data;
            mma_pkg::REG_NUM_COLS:   num_cols_ff   <= csr_data;
            mma_pkg::REG_NUM_COLS_B: num_cols_b_ff <= csr_data;
            default:                 op_mode_ff    <= op_mode_ff;
         endcase
      end
   end

   // Size and load-count check
   assign dims_ok = (num_rows_ff != '0)   && (num_rows_ff   <= NW'(mma_pkg::MAX_DIM)) &&
                    (num_cols_ff != '0)   && (num_cols_ff   <= NW'(mma_pkg::MAX_DIM)) &&
                    (num_cols_b_ff != '0) && (num_cols_b_ff <= NW'(mma_pkg::MAX_DIM));
   assign rc  = PW'(num_rows_ff) * PW'(num_cols_ff);
   assign ccb = PW'(num_cols_ff) * PW'(num_cols_b_ff);
   assign first_ok = (PW'(first_cnt_ff) == rc);

   always_comb begin
      case (op_mode_ff)
         mma_pkg::OP_MUL: second_ok = (PW'(second_cnt_ff) == ccb);
         mma_pkg::OP_ADD: second_ok = (PW'(second_cnt_ff) == rc);
         mma_pkg::OP_TRN: second_ok = 1'b1;
         default:         second_ok = 1'b0;
      endcase
   end

   assign dp_status.run_ok = dims_ok && first_ok && second_ok;

   // Load counts
   always_comb begin
      first_cnt_in  = first_cnt_ff;
      second_cnt_in = second_cnt_ff;
      if (dp_cmd.clear_counts) begin
         first_cnt_in  = '0;
         second_cnt_in = '0;
      end
      if (dp_cmd.load_a) begin
         first_cnt_in = (first_cnt_ff < CW'(mma_pkg::CAPACITY)) ?
                        first_cnt_ff + CW'(1) : CW'(mma_pkg::CAPACITY + 1);
      end
      if (dp_cmd.load_b) begin
         second_cnt_in = (second_cnt_ff < CW'(mma_pkg::CAPACITY)) ?
                         second_cnt_ff + CW'(1) : CW'(mma_pkg::CAPACITY + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_cnt_ff  <= '0;
         second_cnt_ff <= '0;
      end else begin
         first_cnt_ff  <= first_cnt_in;
         second_cnt_ff <= second_cnt_in;
      end
   end

   // Loop limits and addresses
   always_comb begin
      case (op_mode_ff)
         mma_pkg::OP_ADD: begin
            lim1  = num_rows_ff;
            lim2  = num_cols_ff;
            lim3  = NW'(1);
            a_lin = PW'(idx1_ff) * PW'(num_cols_ff) + PW'(idx2_ff);
            b_lin = a_lin;
         end
         mma_pkg::OP_TRN: begin
            lim1  = num_cols_ff;
            lim2  = num_rows_ff;
            lim3  = NW'(1);
            a_lin = PW'(idx2_ff) * PW'(num_cols_ff) + PW'(idx1_ff);
            b_lin = a_lin;
         end
         default: begin
            lim1  = num_rows_ff;
            lim2  = num_cols_b_ff;
            lim3  = num_cols_ff;
            a_lin = PW'(idx1_ff) * PW'(num_cols_ff) + PW'(idx3_ff);
            b_lin = PW'(idx3_ff) * PW'(num_cols_b_ff) + PW'(idx2_ff);
         end
      endcase
   end

   assign dp_status.k_last    = (idx3_ff == lim3 - NW'(1));
   assign dp_status.elem_last = (idx1_ff == lim1 - NW'(1)) && (idx2_ff == lim2 - NW'(1));

   always_comb begin
      idx1_in = idx1_ff;
      idx2_in = idx2_ff;
      idx3_in = idx3_ff;
      if (dp_cmd.start) begin
         idx1_in = '0;
         idx2_in = '0;
         idx3_in = '0;
      end else if (dp_cmd.issue) begin
         if (!dp_status.k_last) begin
            idx3_in = idx3_ff + NW'(1);
         end
      end else if (dp_cmd.next_elem) begin
         idx3_in = '0;
         if (idx2_ff == lim2 - NW'(1)) begin
            idx2_in = '0;
            idx1_in = idx1_ff + NW'(1);
         end else begin
            idx2_in = idx2_ff + NW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff <= idx1_in;
      idx2_ff <= idx2_in;
      idx3_ff <= idx3_in;
   end

   // Element stores
   always_ff @(posedge clock) begin
      if (dp_cmd.load_a && (first_cnt_ff < CW'(mma_pkg::CAPACITY))) begin
         first_store_ff[first_cnt_ff[AW-1:0]] <= DW'(req_value);
      end
      if (dp_cmd.issue) begin
         a_rd_ff <= first_store_ff[a_lin[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load_b && (second_cnt_ff < CW'(mma_pkg::CAPACITY))) begin
         second_store_ff[second_cnt_ff[AW-1:0]] <= DW'(req_value);
      end
      if (dp_cmd.issue) begin
         b_rd_ff <= second_store_ff[b_lin[AW-1:0]];
      end
   end

   // Multiply / add stage
   always_ff @(posedge clock) begin
      p1_first_ff <= (idx3_ff == '0);
      p1_last_ff  <= dp_status.k_last;
      prod_ff     <= a_rd_ff * b_rd_ff;
      sum_ff      <= a_rd_ff + b_rd_ff;
      a2_ff       <= a_rd_ff;
      p2_first_ff <= p1_first_ff;
      p2_last_ff  <= p1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         p1_valid_ff <= dp_cmd.issue;
         p2_valid_ff <= p1_valid_ff;
         done_ff     <= p2_valid_ff && p2_last_ff;
      end
   end

   // Accumulate stage
   always_comb begin
      case (op_mode_ff)
         mma_pkg::OP_ADD: pick = sum_ff;
         mma_pkg::OP_TRN: pick = a2_ff;
         default:         pick = prod_ff;
      endcase
      acc_in = acc_ff;
      if (p2_valid_ff) begin
         acc_in = p2_first_ff ? pick : acc_ff + pick;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign dp_status.acc_done = done_ff;
   assign rsp_result_value   = dp_cmd.zero_out ? '0 : $signed(acc_ff);

endmodule

@@ rtl/matrix_mul_add_transpose.sv @@
// ----------------------------------------------------------------------------
// matrix_mul_add_transpose
// Integer matrix unit: loads two row-major matrices, then streams A*B, A+B
// or transpose(A) row-major on a run command.
// ----------------------------------------------------------------------------
// Request channel (req_): cmd 0 loads value into the first store, cmd 1 into
// the second, cmd 2 runs the configured operation, cmd 3 is dropped. One
// transfer per cycle is taken while the unit is idle; req_stall is high for
// the whole run, until its last result transfer.
// Result channel (rsp_): one transfer per result element, row-major, with
// rsp_last on the final one. A size or load-count mismatch or unused op_mode
// gives a single transfer with value 0, rsp_last and rsp_error high, in the
// cycle after the run transfer. A multiply element makes one store read per
// inner step through a read/multiply/accumulate pipe of three stages, an
// add or transpose element a single read; the next element starts once its
// result is taken. Under rsp_stall the result holds and the unit waits.
// Write csr_ (op_mode, num_rows, num_cols, num_cols_b) only while idle;
// a write takes effect at once. Reset returns to idle, clears both load
// counts and restores the register defaults; store contents are left as
// they are.
// ----------------------------------------------------------------------------
module matrix_mul_add_transpose (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_write,
   input  logic [mma_pkg::CSR_IDX_W-1:0]             csr_index,
   input  logic [mma_pkg::CSR_DATA_W-1:0]            csr_data,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [mma_pkg::CMD_W-1:0]                 req_cmd,
   input  logic signed [mma_pkg::DATA_WIDTH-1:0]     req_value,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [mma_pkg::DATA_WIDTH-1:0]     rsp_result_value,
   output logic                                      rsp_last,
   output logic                                      rsp_error
);

   mma_pkg::ctrl_cmd_type  dp_cmd;
   mma_pkg::dp_status_type dp_status;

   mma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_last  (rsp_last),
      .rsp_error (rsp_error),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   mma_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_value        (req_value),
      .rsp_result_value (rsp_result_value),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status)
   );

endmodule

@@ rtl/mma_checker.sv @@
// ----------------------------------------------------------------------------
// mma_checker
// Port-level checks for the matrix unit, bound to the top level.
// ----------------------------------------------------------------------------
module mma_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [mma_pkg::DATA_WIDTH-1:0] rsp_result_value,
   input logic                                  rsp_last,
   input logic                                  rsp_error
);

   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !rsp_valid)
      else $error("request taken while a result is pending");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_last && (rsp_result_value == '0)))
      else $error("error result not a single zero last transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_result_value) &&
                                    $stable(rsp_last) && $stable(rsp_error)))
      else $error("stalled result changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("unit not idle after reset");

endmodule

bind matrix_mul_add_transpose mma_checker u_mma_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer matrix unit. It loads the first and
// second stores, runs multiply, add and transpose under changing sizes, and
// compares every streamed element, its last mark and its error flag with an
// in-bench model of the unit. A short table of directed transfers comes
// first. Random load/run sequences follow, most of them sized correctly and
// the rest mis-sized, overfilled or mixed with unused commands. Both channels
// see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int DW  = mma_pkg::DATA_WIDTH;
   localparam int AW  = mma_pkg::ADDR_W;
   localparam int CDW = mma_pkg::CSR_DATA_W;

   localparam logic [mma_pkg::CMD_W-1:0] CMD_NOP      = 2'd3;
   localparam logic [1:0]                OP_UNUSED    = 2'd3;
   localparam int                        RANDOM_ITEMS = 220;
   localparam int                        TIMEOUT_NS   = 5_000_000;

   typedef struct packed {
      logic [DW-1:0] elem;
      logic          last;
      logic          err;
   } matrix_elem_type;

   typedef struct packed {
      logic            is_csr;
      logic [1:0]      sel;
      logic [DW-1:0]   data;
      logic            typed;
      matrix_elem_type want;
   } stim_row_type;

   logic                                clock     = 1'b0;
   logic                                reset     = 1'b1;
   logic                                csr_write = 1'b0;
   logic [mma_pkg::CSR_IDX_W-1:0]       csr_index = '0;
   logic [CDW-1:0]                      csr_data  = '0;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [mma_pkg::CMD_W-1:0]           req_cmd   = CMD_NOP;
   logic signed [DW-1:0]                req_value = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [DW-1:0]                rsp_result_value;
   logic                                rsp_last;
   logic                                rsp_error;

   logic [1:0]    op_sel;
   logic [3:0]    dim_rows;
   logic [3:0]    dim_cols;
   logic [3:0]    dim_cols_b;
   logic [DW-1:0] store_a [mma_pkg::CAPACITY];
   logic [DW-1:0] store_b [mma_pkg::CAPACITY];
   int            count_a = 0;
   int            count_b = 0;

   matrix_elem_type expected_elems [$];
   stim_row_type    directed_rows [$];

   int errors         = 0;
   int runs           = 0;
   int refused_runs   = 0;
   int elems_checked  = 0;
   int transfers_sent = 0;
   int stall_run      = 0;
   bit no_gaps        = 1'b0;

   matrix_mul_add_transpose dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_last         (rsp_last),
      .rsp_error        (rsp_error)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void expect_elem(logic [DW-1:0] v, logic last, logic err);
      matrix_elem_type e;
      e.elem = v;
      e.last = last;
      e.err  = err;
      expected_elems.push_back(e);
   endfunction

   function automatic void load_elem(bit to_b, logic [DW-1:0] v);
      if (!to_b) begin
         if (count_a < mma_pkg::CAPACITY) begin
            store_a[AW'(count_a)] = v;
            count_a++;
         end else begin
            count_a = mma_pkg::CAPACITY + 1;
         end
      end else begin
         if (count_b < mma_pkg::CAPACITY) begin
            store_b[AW'(count_b)] = v;
            count_b++;
         end else begin
            count_b = mma_pkg::CAPACITY + 1;
         end
      end
   endfunction

   function automatic void run_matrix_op();
      int r, c, cb, total, n;
      bit ok;
      logic [DW-1:0] acc;
      r  = int'(dim_rows);
      c  = int'(dim_cols);
      cb = int'(dim_cols_b);
      ok = r >= 1 && r <= mma_pkg::MAX_DIM && c >= 1 && c <= mma_pkg::MAX_DIM &&
           cb >= 1 && cb <= mma_pkg::MAX_DIM && op_sel != OP_UNUSED;
      if (ok) begin
         ok = (count_a == r * c);
         if (op_sel == mma_pkg::OP_MUL)
            ok = ok && (count_b == c * cb);
         else if (op_sel == mma_pkg::OP_ADD)
            ok = ok && (count_b == r * c);
      end
      count_a = 0;
      count_b = 0;
      runs++;
      if (!ok) begin
         refused_runs++;
         expect_elem('0, 1'b1, 1'b1);
         return;
      end
      total = (op_sel == mma_pkg::OP_MUL) ? r * cb : r * c;
      n = 0;
      case (op_sel)
         mma_pkg::OP_MUL: begin
            for (int i = 0; i < r; i++)
               for (int j = 0; j < cb; j++) begin
                  acc = '0;
                  for (int k = 0; k < c; k++)
                     acc = acc + store_a[AW'(i * c + k)] * store_b[AW'(k * cb + j)];
                  expect_elem(acc, n == total - 1, 1'b0);
                  n++;
               end
         end
         mma_pkg::OP_ADD: begin
            for (int i = 0; i < r; i++)
               for (int j = 0; j < c; j++) begin
                  expect_elem(store_a[AW'(i * c + j)] + store_b[AW'(i * c + j)],
                              n == total - 1, 1'b0);
                  n++;
               end
         end
         default: begin
            for (int i = 0; i < c; i++)
               for (int j = 0; j < r; j++) begin
                  expect_elem(store_a[AW'(j * c + i)], n == total - 1, 1'b0);
                  n++;
               end
         end
      endcase
   endfunction

   function automatic void matrix_step(logic [mma_pkg::CMD_W-1:0] cmd, logic [DW-1:0] v);
      case (cmd)
         mma_pkg::CMD_LOAD_A: load_elem(1'b0, v);
         mma_pkg::CMD_LOAD_B: load_elem(1'b1, v);
         mma_pkg::CMD_RUN:    run_matrix_op();
         default:             ;
      endcase
   endfunction

   function automatic int pick_gap();
      int p;
      if (no_gaps)
         return 0;
      p = $urandom_range(0, 99);
      if (p < 60)
         return 0;
      if (p < 92)
         return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   function automatic logic [DW-1:0] rand_elem();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60)
         return $urandom;
      if (p < 80)
         return $urandom_range(0, 20) - 10;
      case ($urandom_range(0, 4))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3:       return 32'h0000_0000;
         default: return 32'h0000_0001;
      endcase
   endfunction

   function automatic int pick_dim();
      int p;
      p = $urandom_range(0, 99);
      if (p < 4)
         return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(9, 15);
      if (p < 78)
         return $urandom_range(1, 4);
      return $urandom_range(5, 8);
   endfunction

   function automatic void add_csr(logic [mma_pkg::CSR_IDX_W-1:0] idx, logic [CDW-1:0] data);
      stim_row_type row;
      row = '0;
      row.is_csr = 1'b1;
      row.sel    = idx;
      row.data   = DW'(data);
      directed_rows.push_back(row);
   endfunction

   function automatic void add_item(logic [mma_pkg::CMD_W-1:0] cmd, logic [DW-1:0] v);
      stim_row_type row;
      row = '0;
      row.sel  = cmd;
      row.data = v;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_checked(logic [mma_pkg::CMD_W-1:0] cmd, logic [DW-1:0] elem,
                                       logic last, logic err);
      stim_row_type row;
      row = '0;
      row.sel       = cmd;
      row.typed     = 1'b1;
      row.want.elem = elem;
      row.want.last = last;
      row.want.err  = err;
      directed_rows.push_back(row);
   endfunction

   function automatic void flag_mismatch(string what, logic [DW-1:0] want,
                                         logic [DW-1:0] got);
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
   endfunction

   task automatic write_reg(input logic [mma_pkg::CSR_IDX_W-1:0] idx,
                            input logic [CDW-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      case (idx)
         mma_pkg::REG_OP_MODE:    op_sel     = data[1:0];
         mma_pkg::REG_NUM_ROWS:   dim_rows   = data;
         mma_pkg::REG_NUM_COLS:   dim_cols   = data;
         mma_pkg::REG_NUM_COLS_B: dim_cols_b = data;
         default:                 ;
      endcase
   endtask

   task automatic send_item(input logic [mma_pkg::CMD_W-1:0] cmd, input logic [DW-1:0] v,
                            input bit typed, input matrix_elem_type want);
      int depth;
      int gap;
      csr_write <= 1'b0;
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_value <= v;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      depth = expected_elems.size();
      matrix_step(cmd, v);
      if (typed) begin
         while (expected_elems.size() > depth)
            void'(expected_elems.pop_back());
         expected_elems.push_back(want);
      end
      if (cmd != CMD_NOP)
         transfers_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results(input int tail);
      req_valid <= 1'b0;
      while (expected_elems.size() != 0)
         @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   always @(posedge clock) begin : stall_pattern
      int pick;
      if (stall_run == 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            rsp_stall <= 1'b0;
            stall_run <= $urandom_range(30, 80);
         end else if (pick < 55) begin
            rsp_stall <= 1'b0;
            stall_run <= $urandom_range(1, 6);
         end else if (pick < 93) begin
            rsp_stall <= 1'b1;
            stall_run <= $urandom_range(1, 3);
         end else begin
            rsp_stall <= 1'b1;
            stall_run <= $urandom_range(8, 30);
         end
      end else begin
         stall_run <= stall_run - 1;
      end
   end

   always @(posedge clock) begin : check_results
      matrix_elem_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_elems.size() == 0) begin
            flag_mismatch("unexpected transfer, value", '0, rsp_result_value);
         end else begin
            want = expected_elems.pop_front();
            elems_checked++;
            if (rsp_result_value !== want.elem)
               flag_mismatch("result_value", want.elem, rsp_result_value);
            if (rsp_last !== want.last)
               flag_mismatch("last", DW'(want.last), DW'(rsp_last));
            if (rsp_error !== want.err)
               flag_mismatch("error", DW'(want.err), DW'(rsp_error));
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin : stimulus
      matrix_elem_type none;
      stim_row_type    row;
      bit              prev_csr;
      int              sent, phase, a_left, b_left, r, c, cb;
      logic [1:0]      op;
      logic [1:0]      junk;
      none       = '0;
      op_sel     = mma_pkg::OP_MUL;
      dim_rows   = 4'd8;
      dim_cols   = 4'd8;
      dim_cols_b = 4'd8;
      op         = mma_pkg::OP_MUL;
      r          = 8;
      c          = 8;
      cb         = 8;

      add_checked(mma_pkg::CMD_RUN, 32'h0, 1'b1, 1'b1);
      add_csr(mma_pkg::REG_OP_MODE, CDW'(mma_pkg::OP_ADD));
      add_csr(mma_pkg::REG_NUM_ROWS, 4'd1);
      add_csr(mma_pkg::REG_NUM_COLS, 4'd1);
      add_item(mma_pkg::CMD_LOAD_A, 32'h7fff_ffff);
      add_item(mma_pkg::CMD_LOAD_B, 32'h0000_0001);
      add_checked(mma_pkg::CMD_RUN, 32'h8000_0000, 1'b1, 1'b0);
      add_item(mma_pkg::CMD_LOAD_A, 32'h8000_0000);
      add_item(mma_pkg::CMD_LOAD_B, 32'h8000_0000);
      add_checked(mma_pkg::CMD_RUN, 32'h0, 1'b1, 1'b0);
      add_csr(mma_pkg::REG_OP_MODE, CDW'(mma_pkg::OP_MUL));
      add_csr(mma_pkg::REG_NUM_COLS_B, 4'd1);
      add_item(mma_pkg::CMD_LOAD_A, 32'hffff_ffff);
      add_item(mma_pkg::CMD_LOAD_B, 32'h8000_0000);
      add_checked(mma_pkg::CMD_RUN, 32'h8000_0000, 1'b1, 1'b0);
      add_csr(mma_pkg::REG_OP_MODE, CDW'(mma_pkg::OP_TRN));
      add_csr(mma_pkg::REG_NUM_ROWS, 4'd2);
      add_csr(mma_pkg::REG_NUM_COLS, 4'd3);
      add_item(mma_pkg::CMD_LOAD_A, 32'h8000_0000);
      add_item(mma_pkg::CMD_LOAD_A, 32'h7fff_ffff);
      add_item(mma_pkg::CMD_LOAD_A, 32'hffff_ffff);
      add_item(mma_pkg::CMD_LOAD_A, 32'h0000_0000);
      add_item(mma_pkg::CMD_LOAD_A, 32'h1234_5678);
      add_item(mma_pkg::CMD_LOAD_A, 32'ha5a5_a5a5);
      add_item(CMD_NOP, 32'hffff_ffff);
      add_item(mma_pkg::CMD_RUN, 32'hffff_ffff);
      add_csr(mma_pkg::REG_OP_MODE, CDW'(OP_UNUSED));
      add_checked(mma_pkg::CMD_RUN, 32'h0, 1'b1, 1'b1);
      add_csr(mma_pkg::REG_OP_MODE, CDW'(mma_pkg::OP_TRN));
      add_csr(mma_pkg::REG_NUM_ROWS, 4'd0);
      add_checked(mma_pkg::CMD_RUN, 32'h0, 1'b1, 1'b1);
      add_csr(mma_pkg::REG_NUM_ROWS, 4'hf);
      add_item(mma_pkg::CMD_LOAD_A, 32'h0000_0001);
      add_checked(mma_pkg::CMD_RUN, 32'h0, 1'b1, 1'b1);
      add_csr(mma_pkg::REG_OP_MODE, CDW'(mma_pkg::OP_MUL));
      add_csr(mma_pkg::REG_NUM_ROWS, 4'd1);
      add_csr(mma_pkg::REG_NUM_COLS, 4'd1);
      add_item(mma_pkg::CMD_LOAD_A, 32'h0000_0005);
      add_checked(mma_pkg::CMD_RUN, 32'h0, 1'b1, 1'b1);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      prev_csr = 1'b0;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_csr) begin
            if (!prev_csr)
               drain_results(6);
            write_reg(row.sel, row.data[CDW-1:0]);
         end else begin
            send_item(row.sel, row.data, row.typed, row.want);
         end
         prev_csr = row.is_csr;
      end

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         if (phase < 2 || $urandom_range(0, 3) != 0) begin
            if (phase == 0) begin
               op = mma_pkg::OP_MUL;
               r  = mma_pkg::MAX_DIM;
               c  = mma_pkg::MAX_DIM;
               cb = mma_pkg::MAX_DIM;
            end else if (phase == 1) begin
               op = mma_pkg::OP_TRN;
               r  = mma_pkg::MAX_DIM;
               c  = mma_pkg::MAX_DIM;
               cb = pick_dim();
            end else begin
               op = ($urandom_range(0, 19) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
               r  = pick_dim();
               c  = pick_dim();
               cb = pick_dim();
            end
            junk = ($urandom_range(0, 1) != 0) ? 2'($urandom_range(0, 3)) : 2'd0;
            drain_results(6);
            write_reg(mma_pkg::REG_OP_MODE, {junk, op});
            write_reg(mma_pkg::REG_NUM_ROWS, CDW'(r));
            write_reg(mma_pkg::REG_NUM_COLS, CDW'(c));
            write_reg(mma_pkg::REG_NUM_COLS_B, CDW'(cb));
         end

         if (op == OP_UNUSED || r < 1 || r > mma_pkg::MAX_DIM || c < 1 ||
             c > mma_pkg::MAX_DIM || cb < 1 || cb > mma_pkg::MAX_DIM) begin
            a_left = $urandom_range(0, 4);
            b_left = $urandom_range(0, 4);
         end else begin
            a_left = r * c;
            case (op)
               mma_pkg::OP_MUL: b_left = c * cb;
               mma_pkg::OP_ADD: b_left = r * c;
               default:         b_left = $urandom_range(0, 3);
            endcase
         end
         if (phase == 1) begin
            a_left = mma_pkg::CAPACITY + 1 + $urandom_range(0, 2);
            b_left = 0;
         end else if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 1) != 0)
               a_left = (a_left > 0 && $urandom_range(0, 1) != 0) ? a_left - 1 : a_left + 1;
            else
               b_left = (b_left > 0 && $urandom_range(0, 1) != 0) ? b_left - 1 : b_left + 1;
         end

         while (a_left + b_left > 0) begin
            if ($urandom_range(0, 19) == 0)
               send_item(CMD_NOP, $urandom, 1'b0, none);
            if (a_left > 0 && (b_left == 0 || $urandom_range(0, 1) != 0)) begin
               send_item(mma_pkg::CMD_LOAD_A, rand_elem(), 1'b0, none);
               a_left--;
            end else begin
               send_item(mma_pkg::CMD_LOAD_B, rand_elem(), 1'b0, none);
               b_left--;
            end
            sent++;
         end
         send_item(mma_pkg::CMD_RUN, $urandom, 1'b0, none);
         sent++;
         phase++;
      end

      drain_results(20);
      $display("tb_top: %0d load/run transfers, %0d runs of which %0d refused",
               transfers_sent, runs, refused_runs);
      $display("tb_top: %0d result elements compared, %0d mismatches", elems_checked, errors);
      if (errors == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

@@ matrix_mul_add_transpose.f @@
rtl/mma_pkg.sv
rtl/mma_ctrl.sv
rtl/mma_dp.sv
rtl/matrix_mul_add_transpose.sv
rtl/mma_checker.sv
test/tb_top.sv
